>>> hw/rtl/pip_pkg.sv
// Shared constants and types of the point-in-polygon test block.
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = IDX_W + 1;
  localparam int COORD_W = 32;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int IN_DATA_W = ((IDX_W + 2 * COORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = 8;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TEST  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

>>> hw/rtl/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/point_in_polygon_test.sv
// Top level of the crossing-number point-in-polygon test over a stored vertex list.
//
// Channel  Direction  Signals                            Moves
// s_axis   in         tvalid tready tdata tuser          vertex write or test point
// m_axis   out        tvalid tready tdata                inside flag of one test
// cfg      in         cfg_we cfg_data                    vertex_count register
//
// A vertex write goes to the vertex RAM as it is accepted. A test holds the input off until
// the block is idle again: the single read port of the vertex RAM delivers one vertex per
// cycle (n + 1 reads), the subtract, multiply and compare pipeline then drains, the result
// is handed to the output register and the block returns to idle. A test with no vertices
// skips the reads and goes straight to the hand-off to the output register.
// Synchronous reset clears the control state; the vertex RAM is not cleared.
// While a result waits on m_axis, the next word is still accepted; a following
// test holds its result until the output register is free.
module point_in_polygon_test (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // vertex_index, coord_x, coord_y, zero fill
  input  logic [pip_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // op
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // inside_res, zero fill
  output logic [pip_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [pip_pkg::CNT_W-1:0]        cfg_data
);

  import pip_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]           vertex_count;
  logic [CNT_W-1:0]           n_lim;
  logic [CNT_W-1:0]           cnt_clamped;
  logic [CNT_W-1:0]           k;
  logic signed [COORD_W-1:0]  tx, ty;
  logic signed [COORD_W-1:0]  prev_x, prev_y;

  logic                       in_acc;
  logic                       test_acc;
  logic                       write_acc;
  logic [IDX_W-1:0]           in_index;
  logic signed [COORD_W-1:0]  in_x, in_y;

  logic                       ram_re;
  logic [IDX_W-1:0]           ram_raddr;
  logic [2*COORD_W-1:0]       ram_rdata;
  logic signed [COORD_W-1:0]  cur_x, cur_y;

  logic                       rd_v, rd_first;
  logic                       a_v, a_str, a_dneg;
  logic signed [DIFF_W-1:0]   a_dxt, a_d, a_dxe, a_dyt;
  logic                       b_v, b_str, b_dneg;
  logic signed [PROD_W-1:0]   b_lhs, b_rhs;
  logic                       toggle;
  logic                       odd_cross;
  logic                       out_valid, out_bit;
  logic                       out_load;

  assign in_index  = s_axis_tdata[IDX_W-1:0];
  assign in_x      = s_axis_tdata[IDX_W+COORD_W-1:IDX_W];
  assign in_y      = s_axis_tdata[IDX_W+2*COORD_W-1:IDX_W+COORD_W];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign test_acc  = in_acc && (s_axis_tuser == OP_TEST);
  assign write_acc = in_acc && (s_axis_tuser == OP_WRITE);

  assign cnt_clamped = (vertex_count > CNT_W'(MAX_VERTICES)) ?
                       CNT_W'(MAX_VERTICES) : vertex_count;

  assign cur_x = ram_rdata[COORD_W-1:0];
  assign cur_y = ram_rdata[2*COORD_W-1:COORD_W];

  pip_ram #(
    .WIDTH(2 * COORD_W),
    .DEPTH(MAX_VERTICES)
  ) u_vertex_ram (
    .clk  (clk),
    .we   (write_acc),
    .waddr(in_index),
    .wdata({in_y, in_x}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (test_acc) begin
          state_next = (cnt_clamped == '0) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (k == n_lim) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v && !a_v && !b_v) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    ram_raddr     = (k == '0) ? n_lim[IDX_W-1:0] - IDX_W'(1) : k[IDX_W-1:0] - IDX_W'(1);
    case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_RUN:    ram_re        = 1'b1;
      ST_DRAIN:  ram_re        = 1'b0;
      ST_FINISH: out_load      = !out_valid || m_axis_tready;
      default:   s_axis_tready = 1'b0;
    endcase
  end

  assign toggle = b_v && b_str &&
                  ((!b_dneg && (b_lhs < b_rhs)) || (b_dneg && (b_lhs > b_rhs)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= '0;
      k            <= '0;
      rd_v         <= 1'b0;
      rd_first     <= 1'b0;
      a_v          <= 1'b0;
      b_v          <= 1'b0;
      odd_cross    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      if (test_acc) begin
        k         <= '0;
        odd_cross <= 1'b0;
      end else if (state == ST_RUN) begin
        k <= k + CNT_W'(1);
      end
      rd_v     <= (state == ST_RUN);
      rd_first <= (state == ST_RUN) && (k == '0);
      a_v      <= rd_v && !rd_first;
      b_v      <= a_v;
      if (toggle) begin
        odd_cross <= !odd_cross;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (test_acc) begin
      tx    <= in_x;
      ty    <= in_y;
      n_lim <= cnt_clamped;
    end
    if (rd_v) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    a_str  <= (cur_y > ty) != (prev_y > ty);
    a_dxt  <= DIFF_W'(tx) - DIFF_W'(cur_x);
    a_d    <= DIFF_W'(prev_y) - DIFF_W'(cur_y);
    a_dneg <= prev_y < cur_y;
    a_dxe  <= DIFF_W'(prev_x) - DIFF_W'(cur_x);
    a_dyt  <= DIFF_W'(ty) - DIFF_W'(cur_y);
    b_str  <= a_str;
    b_dneg <= a_dneg;
    b_lhs  <= a_dxt * a_d;
    b_rhs  <= a_dxe * a_dyt;
    if (out_load) begin
      out_bit <= odd_cross;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_bit};

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !rd_v && !a_v && !b_v)
    else $error("edge pipeline busy while idle");

  a_test_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    test_acc |=> state != ST_IDLE)
    else $error("accepted test did not start");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> k <= n_lim)
    else $error("vertex read beyond vertex count");

  a_finish_waits: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && out_valid && !m_axis_tready |=> state == ST_FINISH)
    else $error("result dropped while output register full");

endmodule
